// ===== rtl/pre_pkg.sv =====
`timescale 1ns / 1ps
// Package for the page replacement engine: sizes, codes, payload and
// controller/datapath interface types. Used by every module in rtl/.
package pre_pkg;

  localparam int FRAMES     = 16;
  localparam int PAGES      = 256;
  localparam int COUNT_BITS = 16;
  localparam int SLOT_BITS  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int HIST_BITS  = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int NF_BITS    = $clog2(FRAMES + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [15:0] FAULT_MAX = 16'hFFFF;

  localparam logic [1:0] POLICY_FIFO = 2'd0;
  localparam logic [1:0] POLICY_LRU  = 2'd1;
  localparam logic [1:0] POLICY_LFU  = 2'd2;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_FRAMES = 1'b1;

  localparam logic OP_REF   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] page;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
    logic       evicted_valid;
    logic [7:0] evicted_page;
    logic [15:0] fault_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_LOOK,
    ST_SEARCH,
    ST_COMMIT,
    ST_SEND,
    ST_CLEAR_SWEEP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sweep;       // clear one history entry at the sweep address
    logic load;        // capture the input item, read history
    logic look;        // register hit/empty lookup, write history
    logic search_step; // compare one frame in the victim search
    logic commit;      // update frames and build the result
    logic clear_run;   // clear frame state and counters
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_done;
    logic is_clear;
    logic need_search;
    logic search_done;
  } status_t;

endpackage

// ===== rtl/pre_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the page replacement engine.
// Depends on pre_pkg; drives the datapath by cmd_t and reads status_t.
module pre_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  pre_pkg::status_t status,
  output pre_pkg::cmd_t    cmd
);
  import pre_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (status.sweep_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (status.is_clear) begin
          cmd.clear_run = 1'b1;
          state_next = ST_CLEAR_SWEEP;
        end else begin
          cmd.look = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!status.need_search || status.search_done) begin
          state_next = ST_COMMIT;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      // A clear sweeps the history, then sends its all-zero result.
      ST_CLEAR_SWEEP: begin
        cmd.sweep = 1'b1;
        if (status.sweep_done) begin
          state_next = ST_SEND;
        end
      end
      default: state_next = ST_SWEEP;
    endcase
  end

endmodule

// ===== rtl/pre_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the page replacement engine: frame table, history memory,
// victim search and result register. Depends on pre_pkg.
module pre_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [4:0]          cfg_index,
  input  logic [4:0]          cfg_data,
  input  pre_pkg::in_item_t   in_item,
  input  pre_pkg::cmd_t       cmd,
  output pre_pkg::status_t    status,
  output pre_pkg::out_item_t  out_item
);
  import pre_pkg::*;

  // Configuration registers.
  logic [1:0] policy;
  logic [4:0] frames_in_use;
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POLICY_FIFO;
      frames_in_use <= 5'd4;
    end else if (cfg_write) begin
      if (cfg_index == {4'd0, REG_POLICY}) policy <= cfg_data[1:0];
      else if (cfg_index == {4'd0, REG_FRAMES}) frames_in_use <= cfg_data;
    end
  end

  // Effective frame count, clamped to 1..FRAMES.
  logic [NF_BITS-1:0] nf;
  always_comb begin
    if (frames_in_use == 5'd0) nf = NF_BITS'(1);
    else if ({27'd0, frames_in_use} > FRAMES) nf = NF_BITS'(FRAMES);
    else nf = NF_BITS'(frames_in_use);
  end

  // Frame table and run counters.
  logic [7:0]            frame_page  [FRAMES];
  logic [FRAMES-1:0]     frame_valid;
  logic [COUNT_BITS-1:0] frame_last  [FRAMES];
  logic [COUNT_BITS-1:0] frame_use   [FRAMES];
  logic [SLOT_BITS-1:0]  fifo_next;
  logic [COUNT_BITS-1:0] ref_count;
  logic [15:0]           fault_count;

  // History memory with a clearing sweep after reset and each clear.
  logic [COUNT_BITS-1:0] hist_mem [PAGES];
  logic [HIST_BITS:0]    sweep_addr;
  logic [COUNT_BITS-1:0] hist_rd;
  logic [HIST_BITS-1:0]  hidx;
  logic [HIST_BITS-1:0]  hidx_q;
  logic [COUNT_BITS-1:0] hist_new;

  assign hidx = HIST_BITS'(in_item.page);
  assign hist_new = (hist_rd == COUNT_MAX) ? COUNT_MAX : hist_rd + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      hist_mem[sweep_addr[HIST_BITS-1:0]] <= '0;
    end else if (cmd.look) begin
      hist_mem[hidx_q] <= hist_new;
    end
    if (cmd.load) begin
      hist_rd <= hist_mem[hidx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_run) begin
      sweep_addr <= '0;
    end else if (cmd.sweep && !status.sweep_done) begin
      sweep_addr <= sweep_addr + 1'b1;
    end
  end
  assign status.sweep_done = (sweep_addr == (HIST_BITS+1)'(PAGES - 1));

  // Captured item.
  in_item_t             item;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
      hidx_q <= hidx;
    end
  end
  assign status.is_clear = (item.operation == OP_CLEAR);

  // Hit and empty lookup over usable slots, lowest first.
  logic                 hit_c, empty_c;
  logic [SLOT_BITS-1:0] hit_slot_c, empty_slot_c;
  always_comb begin
    hit_c = 1'b0;
    empty_c = 1'b0;
    hit_slot_c = '0;
    empty_slot_c = '0;
    for (int s = FRAMES - 1; s >= 0; s--) begin
      if (NF_BITS'(s) < nf) begin
        if (frame_valid[s] && frame_page[s] == item.page) begin
          hit_c = 1'b1;
          hit_slot_c = SLOT_BITS'(s);
        end
        if (!frame_valid[s]) begin
          empty_c = 1'b1;
          empty_slot_c = SLOT_BITS'(s);
        end
      end
    end
  end

  // Lookup result and victim search registers.
  logic                  hit_q, empty_q;
  logic [SLOT_BITS-1:0]  slot_q;
  logic [COUNT_BITS-1:0] hist_q, stamp_q;
  logic [NF_BITS-1:0]    scan;
  logic [COUNT_BITS-1:0] best_key;
  logic                  searching;
  logic [SLOT_BITS-1:0]  fifo_slot;

  assign fifo_slot = ({1'b0, fifo_next} < (SLOT_BITS+1)'(nf)) ? fifo_next : '0;
  assign searching = !hit_q && !empty_q &&
                     (policy == POLICY_LRU || policy == POLICY_LFU);
  assign status.need_search = searching;
  assign status.search_done = (scan >= nf);

  logic [COUNT_BITS-1:0] scan_key;
  always_comb begin
    scan_key = '0;
    if (scan < NF_BITS'(FRAMES)) begin
      scan_key = (policy == POLICY_LRU) ? frame_last[scan[SLOT_BITS-1:0]]
                                        : frame_use[scan[SLOT_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      hit_q <= hit_c;
      empty_q <= empty_c;
      hist_q <= hist_new;
      stamp_q <= ref_count;
      scan <= NF_BITS'(1);
      if (hit_c) slot_q <= hit_slot_c;
      else if (empty_c) slot_q <= empty_slot_c;
      else if (policy == POLICY_LRU) begin
        slot_q <= '0;
        best_key <= frame_last[0];
      end else if (policy == POLICY_LFU) begin
        slot_q <= '0;
        best_key <= frame_use[0];
      end else slot_q <= fifo_slot;
    end else if (cmd.search_step) begin
      if (scan_key < best_key) begin
        best_key <= scan_key;
        slot_q <= scan[SLOT_BITS-1:0];
      end
      scan <= scan + 1'b1;
    end
  end

  // Commit: frame update, counters and result register.
  logic [15:0] fault_next;
  assign fault_next = (fault_count == FAULT_MAX) ? FAULT_MAX : fault_count + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      frame_last[slot_q] <= stamp_q;
      frame_use[slot_q] <= hist_q;
      if (!hit_q) frame_page[slot_q] <= item.page;
    end else if (cmd.clear_run) begin
      for (int s = 0; s < FRAMES; s++) begin
        frame_page[s] <= '0;
        frame_last[s] <= '0;
        frame_use[s] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_run) begin
      frame_valid <= '0;
      fifo_next <= '0;
      ref_count <= '0;
      fault_count <= '0;
    end else begin
      if (cmd.look) begin
        ref_count <= (ref_count == COUNT_MAX) ? COUNT_MAX : ref_count + 1'b1;
      end
      if (cmd.commit && !hit_q) begin
        frame_valid[slot_q] <= 1'b1;
        fault_count <= fault_next;
        if (!empty_q && policy != POLICY_LRU && policy != POLICY_LFU) begin
          fifo_next <= ((NF_BITS+1)'(slot_q) + 1'b1 >= (NF_BITS+1)'(nf))
                       ? '0 : slot_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_run) begin
      out_item <= '0;
    end else if (cmd.commit) begin
      out_item.hit <= hit_q;
      out_item.slot <= 4'(slot_q);
      out_item.evicted_valid <= !hit_q && !empty_q;
      out_item.evicted_page <= (!hit_q && !empty_q) ? frame_page[slot_q] : 8'd0;
      out_item.fault_count <= hit_q ? fault_count : fault_next;
    end
  end

endmodule

// ===== rtl/page_replacement_engine.sv =====
`timescale 1ns / 1ps
// Top level of the page replacement engine (FIFO, LRU, LFU policies).
// Depends on pre_pkg, pre_ctrl and pre_datapath.
//
//   channel  signals                          transfer when
//   in       in_valid, in_stall, in_item      in_valid && !in_stall
//   out      out_valid, out_stall, out_item   out_valid && !out_stall
//   cfg      cfg_write, cfg_index, cfg_data   cfg_write
//
// On a hit or fill out_valid rises in SEND, after LOOK, SEARCH and COMMIT
// follow the input transfer; the next input can be taken in the cycle after
// the result transfer. An LRU or LFU eviction adds a victim search over the
// usable frames. After reset and after each clear the history memory is
// swept, one entry a cycle, with in_stall high; a clear's all-zero result
// follows its sweep. One item is in flight; a stalled result holds.
module page_replacement_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [4:0]         cfg_index,
  input  logic [4:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  pre_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output pre_pkg::out_item_t out_item
);
  import pre_pkg::*;

  cmd_t    cmd;
  status_t status;

  pre_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .cmd(cmd)
  );

  pre_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_item(in_item), .cmd(cmd), .status(status),
    .out_item(out_item)
  );

`ifndef SYNTHESIS
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.hit) |-> !out_item.evicted_valid)
    else $error("eviction reported on a hit");
`endif

endmodule
